/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, held off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Invariant checked at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

`endif

/* src/settbl_pkg.sv */
`timescale 1ns / 1ps

package settbl_pkg;

   localparam int DEFAULT_CAPACITY = 32;

   localparam logic [1:0] KIND_INSERT  = 2'd0;
   localparam logic [1:0] KIND_DELETE  = 2'd1;
   localparam logic [1:0] KIND_LOOKUP  = 2'd2;
   localparam logic [1:0] KIND_ORDERED = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic       present;
      logic       changed;
      logic       refused_full;
      logic [5:0] occupancy;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;         // latch request, clear flags, rewind index
      logic scan_rd;      // read entry at index, advance index
      logic set_pos_end;  // insert position is the end of the table
      logic set_pos_ord;  // insert position is first greater entry, else the end; index to end
      logic set_refused;
      logic sh_rd;        // read entry below index
      logic sh_wr;        // move read entry up to index, step index down
      logic del_rd;       // read last entry
      logic del_wr;       // last entry into the matching slot, count down
      logic ins_wr;       // write value at position, count up
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] kind;
      logic       hit;
      logic       gt_found;
      logic       full;
      logic       idx_lt_count;
      logic       shift_last;
      logic       rsp_free;
   } sts_type;

endpackage

/* src/settbl_ctrl.sv */
`timescale 1ns / 1ps

module settbl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  settbl_pkg::sts_type sts,
   output settbl_pkg::cmd_type cmd
);
   import settbl_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_SCAN     = 8'b0000_0010,
      ST_DECIDE   = 8'b0000_0100,
      ST_SHIFT_RD = 8'b0000_1000,
      ST_SHIFT_WR = 8'b0001_0000,
      ST_DEL_WR   = 8'b0010_0000,
      ST_WRITE    = 8'b0100_0000,
      ST_RESP     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.idx_lt_count) begin
               cmd.scan_rd = 1'b1;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_RESP;
            case (sts.kind)
               KIND_INSERT, KIND_ORDERED: begin
                  if (!sts.hit) begin
                     if (sts.full) begin
                        cmd.set_refused = 1'b1;
                     end else if (sts.kind == KIND_INSERT) begin
                        cmd.set_pos_end = 1'b1;
                        state_in        = ST_WRITE;
                     end else begin
                        cmd.set_pos_ord = 1'b1;
                        state_in        = sts.gt_found ? ST_SHIFT_RD : ST_WRITE;
                     end
                  end
               end
               KIND_DELETE: begin
                  if (sts.hit) begin
                     cmd.del_rd = 1'b1;
                     state_in   = ST_DEL_WR;
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_SHIFT_RD: begin
            cmd.sh_rd = 1'b1;
            state_in  = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            cmd.sh_wr = 1'b1;
            state_in  = sts.shift_last ? ST_WRITE : ST_SHIFT_RD;
         end
         ST_DEL_WR: begin
            cmd.del_wr = 1'b1;
            state_in   = ST_RESP;
         end
         ST_WRITE: begin
            cmd.ins_wr = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            // hold until the output register is free
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/settbl_dpath.sv */
`timescale 1ns / 1ps

module settbl_dpath #(
   parameter int CAPACITY = settbl_pkg::DEFAULT_CAPACITY
) (
   input  logic                clock,
   input  logic                reset,
   input  settbl_pkg::req_type req_payload,
   output settbl_pkg::rsp_type rsp_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  settbl_pkg::cmd_type cmd,
   output settbl_pkg::sts_type sts
);
   import settbl_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic [31:0] mem [CAPACITY];

   logic [1:0]         kind_ff;
   logic signed [31:0] value_ff;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      slot_ff, slot_in;
   logic [AW-1:0]      gt_pos_ff, gt_pos_in;
   logic [AW-1:0]      cmp_idx_ff;
   logic               hit_ff, hit_in;
   logic               gt_ff, gt_in;
   logic               cmp_valid_ff;
   logic               changed_ff, changed_in;
   logic               refused_ff, refused_in;
   logic [31:0]        rd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff;

   logic [CW-1:0] idx_m1;
   logic [CW-1:0] count_m1;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;

   assign idx_m1   = idx_ff - CW'(1);
   assign count_m1 = count_ff - CW'(1);

   always_comb begin
      rd_en   = cmd.scan_rd | cmd.sh_rd | cmd.del_rd;
      rd_addr = idx_ff[AW-1:0];
      if (cmd.sh_rd) begin
         rd_addr = idx_m1[AW-1:0];
      end else if (cmd.del_rd) begin
         rd_addr = count_m1[AW-1:0];
      end
   end

   always_comb begin
      wr_en   = cmd.sh_wr | cmd.del_wr | cmd.ins_wr;
      wr_addr = pos_ff[AW-1:0];
      wr_data = value_ff;
      if (cmd.sh_wr) begin
         wr_addr = idx_ff[AW-1:0];
         wr_data = rd_data_ff;
      end else if (cmd.del_wr) begin
         wr_addr = slot_ff;
         wr_data = rd_data_ff;
      end
   end

   always_comb begin
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      slot_in    = slot_ff;
      gt_pos_in  = gt_pos_ff;
      hit_in     = hit_ff;
      gt_in      = gt_ff;
      changed_in = changed_ff;
      refused_in = refused_ff;

      // compare the entry read in the previous scan cycle
      if (cmp_valid_ff) begin
         if (!hit_ff && (rd_data_ff == value_ff)) begin
            hit_in  = 1'b1;
            slot_in = cmp_idx_ff;
         end
         if (!gt_ff && ($signed(rd_data_ff) > value_ff)) begin
            gt_in     = 1'b1;
            gt_pos_in = cmp_idx_ff;
         end
      end

      if (cmd.load) begin
         idx_in     = '0;
         hit_in     = 1'b0;
         gt_in      = 1'b0;
         changed_in = 1'b0;
         refused_in = 1'b0;
      end
      if (cmd.scan_rd) begin
         idx_in = idx_ff + CW'(1);
      end
      if (cmd.set_pos_end) begin
         pos_in = count_ff;
      end
      if (cmd.set_pos_ord) begin
         pos_in = gt_ff ? CW'(gt_pos_ff) : count_ff;
         idx_in = count_ff;
      end
      if (cmd.set_refused) begin
         refused_in = 1'b1;
      end
      if (cmd.sh_wr) begin
         idx_in = idx_m1;
      end
      if (cmd.del_wr) begin
         count_in   = count_m1;
         changed_in = 1'b1;
      end
      if (cmd.ins_wr) begin
         count_in   = count_ff + CW'(1);
         changed_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_payload.kind;
         value_ff <= req_payload.value;
      end
      if (cmd.scan_rd) begin
         cmp_idx_ff <= idx_ff[AW-1:0];
      end
      if (cmd.rsp_load) begin
         rsp_ff.present      <= hit_ff;
         rsp_ff.changed      <= changed_ff;
         rsp_ff.refused_full <= refused_ff;
         rsp_ff.occupancy    <= 6'(count_ff);
      end
      idx_ff     <= idx_in;
      pos_ff     <= pos_in;
      slot_ff    <= slot_in;
      gt_pos_ff  <= gt_pos_in;
      hit_ff     <= hit_in;
      gt_ff      <= gt_in;
      changed_ff <= changed_in;
      refused_ff <= refused_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmp_valid_ff <= cmd.scan_rd;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      sts.kind         = kind_ff;
      sts.hit          = hit_ff;
      sts.gt_found     = gt_ff;
      sts.full         = (count_ff == CW'(CAPACITY));
      sts.idx_lt_count = (idx_ff < count_ff);
      sts.shift_last   = (idx_m1 == pos_ff);
      sts.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

endmodule

/* src/set_table_insert_delete_lookup.sv */
// Sequence: an accepted request scans the stored entries, one read per cycle, then is decided.
// A lookup, a missed delete and a refused or redundant insert go straight to the result;
// an append, an ordered insert and a delete that hits pass a write state first, and an
// ordered insert moves each later entry up by a read and a write. Throughput: one request at
// a time; the result waits for a free output register, and the next is taken once it is loaded.
// Reset: synchronous, active high; empties the table and clears the result slot.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module set_table_insert_delete_lookup #(
   parameter int CAPACITY = settbl_pkg::DEFAULT_CAPACITY
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  settbl_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output settbl_pkg::rsp_type rsp_payload
);
   import settbl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   settbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   settbl_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd),
      .sts         (sts)
   );

   `ASSERT_IMPLIES(a_no_write_when_full, clock, reset, cmd.ins_wr, !sts.full)
   `ASSERT_IMPLIES(a_delete_needs_hit, clock, reset, cmd.del_wr, sts.hit)
   `ASSERT_ALWAYS(a_one_write_port, clock, reset, $onehot0({cmd.sh_wr, cmd.del_wr, cmd.ins_wr}))
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

endmodule

/* sim/set_table_insert_delete_lookup_tb.sv */
`timescale 1ns / 1ps

module set_table_insert_delete_lookup_tb;
   import settbl_pkg::*;

   localparam int CAPACITY     = DEFAULT_CAPACITY;
   localparam int POOL_SIZE    = 40;
   localparam int RANDOM_ITEMS = 1750;
   localparam int BLOCK_ITEMS  = 250;
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 10;
   localparam int HOLD_START   = 400;
   localparam int HOLD_CYCLES  = 300;
   localparam int CALM_FIRST   = 900;
   localparam int CALM_LAST    = 1200;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   req_type            pending_reqs[$];
   rsp_type            expected_rsps[$];
   logic signed [31:0] table_vals[CAPACITY];
   int                 stored;
   int                 error_count;
   int                 sent_count;
   int                 results_seen;
   int                 hold_left;
   bit                 hold_done;
   logic               req_taken;

   set_table_insert_delete_lookup #(
      .CAPACITY(CAPACITY)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic queue_request(input logic [1:0] kind, input logic signed [31:0] value);
      req_type r;
      r.kind  = kind;
      r.value = value;
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   // Apply one request to the shadow table and work out the response it yields
   task automatic apply_set_request(input req_type r, output rsp_type o);
      bit hit;
      int slot;
      int pos;
      hit  = 1'b0;
      slot = 0;
      for (int i = 0; i < stored; i++) begin
         if (!hit && table_vals[i] == r.value) begin
            hit  = 1'b1;
            slot = i;
         end
      end
      o         = '0;
      o.present = hit;
      case (r.kind)
         KIND_INSERT, KIND_ORDERED: begin
            if (!hit) begin
               if (stored >= CAPACITY) begin
                  o.refused_full = 1'b1;
               end else begin
                  pos = stored;
                  // first greater entry in storage order, else the end
                  if (r.kind == KIND_ORDERED) begin
                     for (int i = stored - 1; i >= 0; i--) begin
                        if ($signed(table_vals[i]) > $signed(r.value)) pos = i;
                     end
                  end
                  for (int i = stored; i > pos; i--) table_vals[i] = table_vals[i - 1];
                  table_vals[pos] = r.value;
                  stored++;
                  o.changed = 1'b1;
               end
            end
         end
         KIND_DELETE: begin
            if (hit) begin
               table_vals[slot] = table_vals[stored - 1];
               stored--;
               o.changed = 1'b1;
            end
         end
         default: ;
      endcase
      o.occupancy = 6'(stored);
   endtask

   task automatic check_response(input rsp_type got);
      rsp_type want;
      if (expected_rsps.size() == 0) begin
         report_mismatch($sformatf("response %p with no request outstanding", got));
      end else begin
         want = expected_rsps.pop_front();
         if (got.present !== want.present)
            report_mismatch($sformatf("present %b, expected %b", got.present, want.present));
         if (got.changed !== want.changed)
            report_mismatch($sformatf("changed %b, expected %b", got.changed, want.changed));
         if (got.refused_full !== want.refused_full)
            report_mismatch($sformatf("refused_full %b, expected %b",
                                      got.refused_full, want.refused_full));
         if (got.occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy %0d, expected %0d",
                                      got.occupancy, want.occupancy));
      end
   endtask

   // Sample both handshakes at the rising edge; retire the response before predicting
   always @(posedge clock) begin
      rsp_type predicted;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            check_response(rsp_payload);
            results_seen++;
         end
         if (req_valid && req_ready) begin
            apply_set_request(req_payload, predicted);
            expected_rsps.insert(expected_rsps.size(), predicted);
         end
      end
   end

   // Request driver: hold the payload until taken, then advance or idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_reqs.size() > 0 &&
             ((sent_count >= CALM_FIRST && sent_count < CALM_LAST) ||
              $urandom_range(99) >= 30)) begin
            req_valid   <= 1'b1;
            req_payload <= pending_reqs.pop_front();
            sent_count++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response acceptor: random back-pressure, one long hold-off, one calm stretch
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_START) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (results_seen >= CALM_FIRST && results_seen < CALM_LAST) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 30);
      end
   end

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic signed [31:0] value_pool[POOL_SIZE];
      logic signed [31:0] v;
      logic [1:0]         k;
      int                 mode;
      int                 r;
      int                 th_ins[4];
      int                 th_del[4];
      int                 th_look[4];

      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      rsp_ready    = 1'b0;
      stored       = 0;
      error_count  = 0;
      sent_count   = 0;
      results_seen = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
      for (int i = 0; i < CAPACITY; i++) table_vals[i] = '0;

      // cumulative weights: balanced, fill, drain, mostly ordered
      th_ins  = '{30, 45, 15, 0};
      th_del  = '{55, 55, 65, 5};
      th_look = '{80, 70, 85, 40};

      // empty table, extremes, redundant inserts, ordered insert into an unordered table
      queue_request(KIND_LOOKUP,  32'sd0);
      queue_request(KIND_DELETE,  32'sd5);
      queue_request(KIND_INSERT,  32'sh7FFFFFFF);
      queue_request(KIND_INSERT,  32'sh80000000);
      queue_request(KIND_INSERT,  32'sh7FFFFFFF);
      queue_request(KIND_ORDERED, 32'sd0);
      queue_request(KIND_ORDERED, 32'sh80000000);
      queue_request(KIND_LOOKUP,  32'sh80000000);
      queue_request(KIND_LOOKUP,  32'sd7);
      queue_request(KIND_DELETE,  32'sh7FFFFFFF);
      queue_request(KIND_DELETE,  32'sh80000000);
      queue_request(KIND_DELETE,  32'sh80000000);
      queue_request(KIND_ORDERED, -32'sd1);
      queue_request(KIND_ORDERED, 32'sd5);
      queue_request(KIND_ORDERED, 32'sd3);
      queue_request(KIND_INSERT,  32'sd2);
      queue_request(KIND_ORDERED, 32'sd1);
      queue_request(KIND_ORDERED, 32'sd4);
      queue_request(KIND_ORDERED, 32'sh80000000);
      queue_request(KIND_LOOKUP,  32'sd4);
      queue_request(KIND_DELETE,  -32'sd1);
      queue_request(KIND_ORDERED, -32'sd1);
      queue_request(KIND_LOOKUP,  -32'sd1);

      // a small value pool keeps hits frequent and lets the table reach capacity
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % BLOCK_ITEMS == 0) begin
            for (int i = 0; i < POOL_SIZE; i++) begin
               case ($urandom_range(9))
                  0:       value_pool[i] = 32'sh7FFFFFFF;
                  1:       value_pool[i] = 32'sh80000000;
                  2:       value_pool[i] = $signed(32'($urandom_range(15))) - 32'sd8;
                  default: value_pool[i] = $urandom;
               endcase
            end
         end
         mode = (n / BLOCK_ITEMS) % 4;
         r    = $urandom_range(99);
         if (r < th_ins[mode])       k = KIND_INSERT;
         else if (r < th_del[mode])  k = KIND_DELETE;
         else if (r < th_look[mode]) k = KIND_LOOKUP;
         else                        k = KIND_ORDERED;
         if ($urandom_range(99) < 8) v = $urandom;
         else                        v = value_pool[$urandom_range(POOL_SIZE - 1)];
         queue_request(k, v);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
